FILE: hw/rtl/sis_pkg.sv
package sis_pkg;

   // Request opcodes. The unused code behaves as a status read.
   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_READ = 2'd2
   } opcode_type;

   // Response status codes.
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_POP_EMPTY  = 2'd1,
      ST_PUSH_FULL  = 2'd2
   } status_type;

   // Command broadcast to every cell of the chain. Both are already qualified,
   // so a push is never sent when full and a pop never when empty.
   typedef struct packed {
      logic push;
      logic pop;
   } cell_cmd_type;

endpackage

FILE: hw/rtl/sis_if.sv
// Request channel: opcode and value.
interface sis_req_if #(
   parameter int VALUE_WIDTH = 32
) ();
   logic                          valid;
   logic                          ready;
   logic [1:0]                    opcode;
   logic signed [VALUE_WIDTH-1:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink (input valid, input opcode, input value, output ready);
endinterface

// Response channel: top of stack, count, empty flag and status.
interface sis_rsp_if #(
   parameter int VALUE_WIDTH = 32,
   parameter int COUNT_WIDTH = 5
) ();
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] top_value;
   logic [COUNT_WIDTH-1:0]        entry_count;
   logic                          is_empty;
   logic [1:0]                    status;

   modport source (output valid, output top_value, output entry_count, output is_empty,
                   output status, input ready);
   modport sink (input valid, input top_value, input entry_count, input is_empty,
                 input status, output ready);
endinterface

FILE: hw/rtl/sis_cell.sv
module sis_cell #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sis_pkg::cell_cmd_type         cmd,
   input  logic signed [VALUE_WIDTH-1:0] new_value,
   input  logic                          prev_occ,
   input  logic                          prev_lt,
   input  logic signed [VALUE_WIDTH-1:0] prev_entry,
   input  logic                          next_occ,
   output logic                          occ,
   output logic                          lt,
   output logic                          top,
   output logic signed [VALUE_WIDTH-1:0] entry
);

   logic                          occ_ff;
   logic                          occ_in;
   logic signed [VALUE_WIDTH-1:0] entry_ff;
   logic signed [VALUE_WIDTH-1:0] entry_in;
   logic                          load;

   // This cell holds a value smaller than the one being pushed.
   assign lt    = occ_ff && (entry_ff < new_value);
   assign top   = occ_ff && !next_occ;
   assign occ   = occ_ff;
   assign entry = entry_ff;

   // A push loads a cell whose entry moves up, or the first free cell.
   assign load = cmd.push && (occ_ff ? lt : prev_occ);

   // The loaded value is the neighbor's entry if that one moves up too,
   // otherwise the new value lands here.
   always_comb begin
      entry_in = entry_ff;
      if (load) begin
         entry_in = prev_lt ? prev_entry : new_value;
      end
   end

   // A pop frees only the topmost occupied cell.
   always_comb begin
      occ_in = occ_ff;
      if (load) begin
         occ_in = 1'b1;
      end else if (cmd.pop) begin
         occ_in = occ_ff && next_occ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: hw/rtl/sorted_insert_stack.sv
// Sorted insert stack: a bounded stack of signed values kept in sorted order,
// so the smallest value is always on top.
// Request channel (req): opcode push, pop or status read, and a value used by
// a push. A push goes above every stored value that is not smaller than it, so
// among equal values the newest is on top. A pop removes the top value.
// Response channel (rsp): one response per request with the top value after
// the request (0 when empty), the entry count, an empty flag and a status:
// ok, pop on empty ignored, or push on full dropped.
// The store is a chain of DEPTH cells; every cell compares its entry with the
// pushed value at once and shifts up by one. Each request goes through the
// chain update, then the response register that selects the top cell.
// Throughput is one request per cycle while rsp.ready stays high.
// When the receiver stalls, one response waits in the output register and one
// more in the stage behind it; req.ready then drops until rsp.ready returns.
// Reset empties the store; entry contents need no clearing.
module sorted_insert_stack #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input logic       clock,
   input logic       reset,
   sis_req_if.sink   req,
   sis_rsp_if.source rsp
);

   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   // Chain wiring.
   logic                          cell_occ   [DEPTH];
   logic                          cell_lt    [DEPTH];
   logic                          cell_top   [DEPTH];
   logic signed [VALUE_WIDTH-1:0] cell_entry [DEPTH];
   sis_pkg::cell_cmd_type         cmd;

   // Control and response registers.
   logic [COUNT_WIDTH-1:0]        count_ff;
   logic [COUNT_WIDTH-1:0]        count_in;
   logic                          pend_ff;
   logic                          pend_in;
   sis_pkg::status_type           pend_status_ff;
   sis_pkg::status_type           status_in;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic signed [VALUE_WIDTH-1:0] out_top_ff;
   logic [COUNT_WIDTH-1:0]        out_count_ff;
   sis_pkg::status_type           out_status_ff;
   logic signed [VALUE_WIDTH-1:0] top_mux;
   logic                          accept;
   logic                          pend_move;
   logic                          full;
   logic                          empty;

   // Handshake: the pending stage moves into the output register when it is free.
   assign pend_move = pend_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !pend_ff || pend_move;
   assign accept    = req.valid && req.ready;

   assign full  = (count_ff == COUNT_WIDTH'(DEPTH));
   assign empty = (count_ff == '0);

   // Decode the request into a chain command, a status and the next count.
   always_comb begin
      cmd       = '0;
      status_in = sis_pkg::ST_OK;
      count_in  = count_ff;
      case (sis_pkg::opcode_type'(req.opcode))
         sis_pkg::OP_PUSH: begin
            if (full) begin
               status_in = sis_pkg::ST_PUSH_FULL;
            end else begin
               cmd.push = accept;
               count_in = count_ff + COUNT_WIDTH'(1);
            end
         end
         sis_pkg::OP_POP: begin
            if (empty) begin
               status_in = sis_pkg::ST_POP_EMPTY;
            end else begin
               cmd.pop  = accept;
               count_in = count_ff - COUNT_WIDTH'(1);
            end
         end
         default: begin
            status_in = sis_pkg::ST_OK;
         end
      endcase
   end

   // The chain of cells; cell 0 is the bottom of the stack.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                          prev_occ;
      logic                          prev_lt;
      logic signed [VALUE_WIDTH-1:0] prev_entry;
      logic                          next_occ;

      if (i == 0) begin : g_bottom
         assign prev_occ   = 1'b1;
         assign prev_lt    = 1'b0;
         assign prev_entry = '0;
      end else begin : g_inner
         assign prev_occ   = cell_occ[i-1];
         assign prev_lt    = cell_lt[i-1];
         assign prev_entry = cell_entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_occ = 1'b0;
      end else begin : g_below
         assign next_occ = cell_occ[i+1];
      end

      sis_cell #(
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .new_value  (req.value),
         .prev_occ   (prev_occ),
         .prev_lt    (prev_lt),
         .prev_entry (prev_entry),
         .next_occ   (next_occ),
         .occ        (cell_occ[i]),
         .lt         (cell_lt[i]),
         .top        (cell_top[i]),
         .entry      (cell_entry[i])
      );
   end

   // Select the top cell; at most one flag is set, none when empty.
   always_comb begin
      top_mux = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_top[i]) begin
            top_mux = top_mux | cell_entry[i];
         end
      end
   end

   assign pend_in      = accept || (pend_ff && !pend_move);
   assign out_valid_in = pend_move || (out_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Response payload; the pending request's count is count_ff until it moves.
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_status_ff <= status_in;
      end
      if (pend_move) begin
         out_top_ff    <= top_mux;
         out_count_ff  <= count_ff;
         out_status_ff <= pend_status_ff;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.top_value   = out_top_ff;
   assign rsp.entry_count = out_count_ff;
   assign rsp.is_empty    = (out_count_ff == '0);
   assign rsp.status      = out_status_ff;

endmodule

FILE: tb/sv/tb_sorted_insert_stack.sv
module tb_sorted_insert_stack;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH          = 16;
   localparam int VALUE_WIDTH    = 32;
   localparam int COUNT_WIDTH    = 5;
   localparam int RANDOM_ITEMS   = 430;
   localparam int HOLD_CYCLES    = 80;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   // The opcode that the package leaves unnamed; the block treats it as a status read.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   localparam int FILL_VALUES [11] = '{7, 7, -7, 7, 3, 3, -100, 42, 0, -1, 1000};

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] top_value;
      logic [COUNT_WIDTH-1:0]        entry_count;
      logic                          is_empty;
      sis_pkg::status_type           status;
   } stack_report_type;

   logic clock = 1'b0;
   logic reset;

   sis_req_if #(.VALUE_WIDTH(VALUE_WIDTH)) req ();
   sis_rsp_if #(.VALUE_WIDTH(VALUE_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) rsp ();

   sorted_insert_stack #(
      .DEPTH      (DEPTH),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req  (req),
      .rsp  (rsp)
   );

   // Shadow copy of the sorted store; index 0 is the bottom, the top is the smallest value.
   logic signed [VALUE_WIDTH-1:0] shadow_entries [DEPTH];
   int                            shadow_count;

   stack_report_type pending_reports [$];
   int               sent_count;
   int               received_count;
   int               mismatch_count;
   logic             req_gaps_on;
   logic             rsp_stalls_on;
   logic             hold_rsp_request;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Applies one request to the shadow store and returns the report the block should give.
   function automatic stack_report_type apply_request(logic [1:0] op,
                                                      logic signed [VALUE_WIDTH-1:0] val);
      stack_report_type report;
      int               slot;
      report.status = sis_pkg::ST_OK;
      if (op == sis_pkg::OP_PUSH) begin
         if (shadow_count >= DEPTH) begin
            report.status = sis_pkg::ST_PUSH_FULL;
         end else begin
            // Smaller entries move up one place, so the new value lands above all
            // entries that are not smaller, equal ones included.
            slot = shadow_count;
            while (slot > 0 && shadow_entries[slot-1] < val) begin
               shadow_entries[slot] = shadow_entries[slot-1];
               slot--;
            end
            shadow_entries[slot] = val;
            shadow_count++;
         end
      end else if (op == sis_pkg::OP_POP) begin
         if (shadow_count == 0) begin
            report.status = sis_pkg::ST_POP_EMPTY;
         end else begin
            shadow_count--;
         end
      end
      report.top_value   = (shadow_count > 0) ? shadow_entries[shadow_count-1] : '0;
      report.entry_count = COUNT_WIDTH'(shadow_count);
      report.is_empty    = (shadow_count == 0);
      return report;
   endfunction

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Value classes: full range, a narrow band that repeats often, and the extremes.
   function automatic logic signed [VALUE_WIDTH-1:0] pick_value(int kind);
      logic signed [VALUE_WIDTH-1:0] val;
      case (kind)
         0: val = $urandom;
         1: val = VALUE_WIDTH'(int'($urandom_range(0, 8)) - 4);
         default: begin
            case ($urandom_range(0, 5))
               0: val = VALUE_MAX;
               1: val = VALUE_MIN;
               2: val = VALUE_MAX - 1;
               3: val = VALUE_MIN + 1;
               4: val = '0;
               default: val = '1;
            endcase
         end
      endcase
      return val;
   endfunction

   task automatic compare_field(string field, logic signed [VALUE_WIDTH:0] want, got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // Offers one request after an optional gap and returns at the edge that accepts it.
   task automatic send_request(logic [1:0] op, logic signed [VALUE_WIDTH-1:0] val);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid  <= 1'b1;
      req.opcode <= op;
      req.value  <= val;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic wait_for_responses();
      if (received_count != sent_count) begin
         req.valid <= 1'b0;
         while (received_count != sent_count) @(posedge clock);
      end
   endtask

   // A status read, the unused opcode and a pop, all on an empty store.
   task automatic test_empty_store();
      send_request(sis_pkg::OP_READ, VALUE_MAX);
      send_request(OP_UNUSED, VALUE_MIN);
      send_request(sis_pkg::OP_POP, '1);
   endtask

   // Both ends of the value range, zero, minus one and a pair of equal values.
   task automatic test_value_extremes();
      send_request(sis_pkg::OP_PUSH, VALUE_MAX);
      send_request(sis_pkg::OP_PUSH, VALUE_MIN);
      send_request(sis_pkg::OP_PUSH, '0);
      send_request(sis_pkg::OP_PUSH, '1);
      send_request(sis_pkg::OP_PUSH, 1);
      send_request(sis_pkg::OP_PUSH, 1);
      send_request(sis_pkg::OP_POP, VALUE_MAX);
      send_request(sis_pkg::OP_READ, '0);
   endtask

   // Fill the store to the brim, then push once more and read with the unused opcode.
   task automatic test_fill_to_full();
      foreach (FILL_VALUES[i]) send_request(sis_pkg::OP_PUSH, VALUE_WIDTH'(FILL_VALUES[i]));
      send_request(sis_pkg::OP_PUSH, VALUE_MAX);
      send_request(OP_UNUSED, '0);
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_response_backpressure();
      req_gaps_on      = 1'b0;
      rsp_stalls_on    = 1'b0;
      hold_rsp_request = 1'b1;
      repeat (24) begin
         send_request($urandom_range(0, 2) == 0 ? sis_pkg::OP_POP : sis_pkg::OP_PUSH,
                      pick_value(1));
      end
      wait_for_responses();
   endtask

   // The sender stops until every response is in, then carries on.
   task automatic test_pause_until_drained();
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      repeat (12) send_request(sis_pkg::OP_POP, $urandom);
      wait_for_responses();
      repeat (12) send_request(sis_pkg::OP_PUSH, pick_value(0));
   endtask

   // Phases that lean toward pushes, toward pops or neither, each with its own value class.
   task automatic test_random_mix();
      int                            issued;
      int                            phase_len;
      int                            push_pct;
      int                            pop_pct;
      int                            value_kind;
      int                            roll;
      logic [1:0]                    op;
      logic signed [VALUE_WIDTH-1:0] val;
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         phase_len = $urandom_range(10, 60);
         case ($urandom_range(0, 2))
            0: begin
               push_pct = 80;
               pop_pct  = 15;
            end
            1: begin
               push_pct = 25;
               pop_pct  = 70;
            end
            default: begin
               push_pct = 45;
               pop_pct  = 45;
            end
         endcase
         value_kind    = $urandom_range(0, 2);
         req_gaps_on   = ($urandom_range(0, 3) != 0);
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         repeat (phase_len) begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct) op = sis_pkg::OP_PUSH;
            else if (roll < push_pct + pop_pct) op = sis_pkg::OP_POP;
            else op = roll[0] ? sis_pkg::OP_READ : OP_UNUSED;
            val = pick_value(value_kind);
            send_request(op, val);
            issued++;
         end
         // Now and then let everything drain before the next phase.
         if ($urandom_range(0, 4) == 0) wait_for_responses();
      end
   endtask

   // Receiver: random stalls, plus one long hold when a test asks for it.
   initial begin : rsp_ready_driver
      int stall;
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp_request) begin
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp_request = 1'b0;
            rsp.ready <= 1'b1;
         end else if (rsp_stalls_on && $urandom_range(0, 99) < 30) begin
            stall = pick_gap() + 1;
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp.ready <= 1'b1;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // Check each response against the oldest prediction, then predict for a new request.
   always @(posedge clock) begin : response_check
      stack_report_type want;
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            if (pending_reports.size() == 0) begin
               $display("%0t: response mismatch: expected none, actual top %0d count %0d",
                        $time, rsp.top_value, rsp.entry_count);
               mismatch_count++;
            end else begin
               want = pending_reports.pop_front();
               compare_field("top_value", (VALUE_WIDTH+1)'(want.top_value),
                             (VALUE_WIDTH+1)'(rsp.top_value));
               compare_field("entry_count", (VALUE_WIDTH+1)'(want.entry_count),
                             (VALUE_WIDTH+1)'(rsp.entry_count));
               compare_field("is_empty", (VALUE_WIDTH+1)'(want.is_empty),
                             (VALUE_WIDTH+1)'(rsp.is_empty));
               compare_field("status", (VALUE_WIDTH+1)'(want.status),
                             (VALUE_WIDTH+1)'(rsp.status));
               received_count++;
            end
         end
         if (req.valid && req.ready) begin
            pending_reports.insert(pending_reports.size(),
                                   apply_request(req.opcode, req.value));
         end
      end
   end

   // Ends the run when nothing moves on either channel for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("%0t: no request or response accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req.valid        = 1'b0;
      req.opcode       = sis_pkg::OP_READ;
      req.value        = '0;
      shadow_count     = 0;
      sent_count       = 0;
      received_count   = 0;
      mismatch_count   = 0;
      req_gaps_on      = 1'b1;
      rsp_stalls_on    = 1'b1;
      hold_rsp_request = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_empty_store();
      test_value_extremes();
      test_fill_to_full();
      test_response_backpressure();
      test_pause_until_drained();
      test_random_mix();

      // Drain, give the pipeline time to show any stray response, then report.
      wait_for_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_reports.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
